/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the elgsv RTL modules.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ELGSV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ELGSV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/elgsv_pkg.sv */
// Package for the ElGamal signature verifier: widths, register indexes,
// operand selects and the command and status structs. No dependencies.
`default_nettype none

package elgsv_pkg;

   localparam int MSG_W = 63;   // message field width
   localparam int SIG_W = 31;   // signature component width
   localparam int CNT_W = 6;    // bit counter of the modular unit, holds MSG_W

   localparam int RST_MODULUS    = 23;
   localparam int RST_GENERATOR  = 5;
   localparam int RST_PUBLIC_KEY = 17;

   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MODULUS    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GENERATOR  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PUBLIC_KEY = 2'd2;

   // Operand selection for one pass of the shared modular unit.
   typedef enum logic [2:0] {
      SRC_MSG,      // message mod (p - 1)
      SRC_GEN,      // generator mod p
      SRC_KEY,      // public key mod p
      SRC_SIGR,     // r mod p
      SRC_ACCMUL,   // accumulator * base mod p
      SRC_SQR,      // base * base mod p
      SRC_FINAL     // second power * third power mod p
   } src_type;

   typedef struct packed {
      logic    load;
      logic    start;
      src_type src;
      logic    exp_from_unit;
      logic    exp_load_r;
      logic    exp_load_s;
      logic    exp_shift;
      logic    base_from_unit;
      logic    pacc_one;
      logic    pacc_from_unit;
      logic    save_right;
      logic    save_t1;
   } cmd_type;

   typedef struct packed {
      logic unit_done;
      logic exp_zero;
      logic exp_lsb;
      logic p_small;
      logic match;
   } status_type;

endpackage

`default_nettype wire

/* hw/rtl/elgsv_mmu.sv */
// Shared modular unit: bit-serial multiply-and-reduce, also used as a
// serial remainder with addend 1. Depends on elgsv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module elgsv_mmu import elgsv_pkg::*; #(
   parameter int MOD_WIDTH = 31
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [MSG_W-1:0]     x_in,
   input  wire logic [CNT_W-1:0]     nbits,
   input  wire logic [MOD_WIDTH-1:0] addend,
   input  wire logic [MOD_WIDTH-1:0] modulo,
   output logic                      done,
   output logic [MOD_WIDTH-1:0]      result
);

   localparam int TW = MOD_WIDTH + 2;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [MSG_W-1:0]     x_ff, x_in_next;
   logic [MOD_WIDTH-1:0] acc_ff, acc_in;
   logic [MOD_WIDTH-1:0] a_ff, m_ff;
   logic [TW-1:0]        sum, m1, m2, t1, t2;

   // One step: acc = (2 * acc + bit * a) mod m, with acc and a below m.
   always_comb begin
      m1     = {2'b00, m_ff};
      m2     = {1'b0, m_ff, 1'b0};
      sum    = {1'b0, acc_ff, 1'b0} + (x_ff[MSG_W-1] ? {2'b00, a_ff} : '0);
      t1     = (sum >= m2) ? sum - m2 : sum;
      t2     = (t1 >= m1) ? t1 - m1 : t1;
      acc_in = t2[MOD_WIDTH-1:0];
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      x_in_next = x_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = nbits;
         x_in_next = x_in;
      end else if (busy_ff) begin
         cnt_in    = cnt_ff - 1'b1;
         x_in_next = {x_ff[MSG_W-2:0], 1'b0};
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      x_ff   <= x_in_next;
      if (start) begin
         acc_ff <= '0;
         a_ff   <= addend;
         m_ff   <= modulo;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

   `ELGSV_ASSERT(a_start_idle, clock, reset, start |-> !busy_ff, "unit started while busy")
   `ELGSV_ASSERT(a_acc_reduced, clock, reset, busy_ff |-> (acc_ff < m_ff), "partial result not reduced")
   `ELGSV_ASSERT(a_done_pulse, clock, reset, done_ff |=> !done_ff, "done held longer than one cycle")

endmodule

`default_nettype wire

/* hw/rtl/elgsv_dp.sv */
// Datapath: configuration registers, captured item, exponent, base and
// accumulator registers around the shared modular unit. Depends on elgsv_pkg.
`default_nettype none

module elgsv_dp import elgsv_pkg::*; #(
   parameter int MOD_WIDTH = 31
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [MOD_WIDTH-1:0]  csr_wdata,
   input  wire logic [MSG_W-1:0]      message,
   input  wire logic [SIG_W-1:0]      sig_r,
   input  wire logic [SIG_W-1:0]      sig_s,
   input  wire cmd_type               cmd,
   output status_type                 status
);

   localparam int MPAD = MSG_W - MOD_WIDTH;
   localparam int SPAD = MSG_W - SIG_W;

   logic [MOD_WIDTH-1:0] modulus_ff, generator_ff, pubkey_ff;
   logic [MSG_W-1:0]     msg_ff;
   logic [SIG_W-1:0]     sigr_ff, sigs_ff;
   logic [SIG_W-1:0]     exp_ff, exp_in;
   logic [MOD_WIDTH-1:0] base_ff, pacc_ff, right_ff, t1_ff;

   logic [MSG_W-1:0]     u_x;
   logic [CNT_W-1:0]     u_n;
   logic [MOD_WIDTH-1:0] u_a, u_m, u_result;
   logic                 u_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MOD_WIDTH'(RST_MODULUS);
         generator_ff <= MOD_WIDTH'(RST_GENERATOR);
         pubkey_ff    <= MOD_WIDTH'(RST_PUBLIC_KEY);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MODULUS:    modulus_ff   <= csr_wdata;
            CSR_GENERATOR:  generator_ff <= csr_wdata;
            CSR_PUBLIC_KEY: pubkey_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Operands are left-aligned so the unit always consumes from the top bit.
   always_comb begin
      u_m = modulus_ff;
      u_a = MOD_WIDTH'(1);
      u_n = CNT_W'(MOD_WIDTH);
      case (cmd.src)
         SRC_MSG: begin
            u_x = msg_ff;
            u_n = CNT_W'(MSG_W);
            u_m = modulus_ff - 1'b1;
         end
         SRC_GEN:  u_x = {generator_ff, {MPAD{1'b0}}};
         SRC_KEY:  u_x = {pubkey_ff, {MPAD{1'b0}}};
         SRC_SIGR: begin
            u_x = {sigr_ff, {SPAD{1'b0}}};
            u_n = CNT_W'(SIG_W);
         end
         SRC_ACCMUL: begin
            u_x = {base_ff, {MPAD{1'b0}}};
            u_a = pacc_ff;
         end
         SRC_SQR: begin
            u_x = {base_ff, {MPAD{1'b0}}};
            u_a = base_ff;
         end
         SRC_FINAL: begin
            u_x = {t1_ff, {MPAD{1'b0}}};
            u_a = pacc_ff;
         end
         default:  u_x = '0;
      endcase
   end

   elgsv_mmu #(.MOD_WIDTH(MOD_WIDTH)) u_mmu (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start),
      .x_in   (u_x),
      .nbits  (u_n),
      .addend (u_a),
      .modulo (u_m),
      .done   (u_done),
      .result (u_result)
   );

   always_comb begin
      exp_in = exp_ff;
      if (cmd.exp_from_unit) begin
         exp_in = SIG_W'(u_result);
      end else if (cmd.exp_load_r) begin
         exp_in = sigr_ff;
      end else if (cmd.exp_load_s) begin
         exp_in = sigs_ff;
      end else if (cmd.exp_shift) begin
         exp_in = exp_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff <= exp_in;
      if (cmd.load) begin
         msg_ff  <= message;
         sigr_ff <= sig_r;
         sigs_ff <= sig_s;
      end
      if (cmd.base_from_unit) begin
         base_ff <= u_result;
      end
      if (cmd.pacc_one) begin
         pacc_ff <= MOD_WIDTH'(1);
      end else if (cmd.pacc_from_unit) begin
         pacc_ff <= u_result;
      end
      if (cmd.save_right) begin
         right_ff <= pacc_ff;
      end
      if (cmd.save_t1) begin
         t1_ff <= pacc_ff;
      end
   end

   always_comb begin
      status.unit_done = u_done;
      status.exp_zero  = (exp_ff == '0);
      status.exp_lsb   = exp_ff[0];
      status.p_small   = (modulus_ff < MOD_WIDTH'(2));
      status.match     = (u_result == right_ff);
   end

endmodule

`default_nettype wire

/* hw/rtl/elgsv_ctrl.sv */
// Controller: sequences the hash, the base reductions and the three
// square-and-multiply powers, and holds the result beat. Uses elgsv_pkg.
`default_nettype none
`include "assert_macros.svh"

module elgsv_ctrl import elgsv_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       rsp_ready,
   output logic            rsp_valid,
   output logic            rsp_res,
   output cmd_type         cmd,
   input  wire status_type status
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_HASH, S_GEN, S_POW, S_MUL, S_SQ_CHK, S_SQR,
      S_POW_END, S_KEY, S_SIGR, S_FIN, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_RIGHT, PH_KEY, PH_SIGR
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_res_ff, rsp_res_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_res_in   = rsp_res_ff;
      cmd          = '0;
      cmd.src      = SRC_MSG;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            phase_in = PH_RIGHT;
            if (status.p_small) begin
               state_in = S_OUT;
            end else begin
               cmd.start = 1'b1;
               cmd.src   = SRC_MSG;
               state_in  = S_HASH;
            end
         end
         S_HASH: begin
            if (status.unit_done) begin
               cmd.exp_from_unit = 1'b1;
               cmd.start         = 1'b1;
               cmd.src           = SRC_GEN;
               state_in          = S_GEN;
            end
         end
         S_GEN: begin
            if (status.unit_done) begin
               cmd.base_from_unit = 1'b1;
               cmd.pacc_one       = 1'b1;
               state_in           = S_POW;
            end
         end
         S_POW: begin
            if (status.exp_zero) begin
               state_in = S_POW_END;
            end else if (status.exp_lsb) begin
               cmd.start = 1'b1;
               cmd.src   = SRC_ACCMUL;
               state_in  = S_MUL;
            end else begin
               cmd.exp_shift = 1'b1;
               state_in      = S_SQ_CHK;
            end
         end
         S_MUL: begin
            if (status.unit_done) begin
               cmd.pacc_from_unit = 1'b1;
               cmd.exp_shift      = 1'b1;
               state_in           = S_SQ_CHK;
            end
         end
         S_SQ_CHK: begin
            // The base is not squared once no exponent bits remain.
            if (status.exp_zero) begin
               state_in = S_POW_END;
            end else begin
               cmd.start = 1'b1;
               cmd.src   = SRC_SQR;
               state_in  = S_SQR;
            end
         end
         S_SQR: begin
            if (status.unit_done) begin
               cmd.base_from_unit = 1'b1;
               state_in           = S_POW;
            end
         end
         S_POW_END: begin
            case (phase_ff)
               PH_RIGHT: begin
                  cmd.save_right = 1'b1;
                  cmd.start      = 1'b1;
                  cmd.src        = SRC_KEY;
                  phase_in       = PH_KEY;
                  state_in       = S_KEY;
               end
               PH_KEY: begin
                  cmd.save_t1 = 1'b1;
                  cmd.start   = 1'b1;
                  cmd.src     = SRC_SIGR;
                  phase_in    = PH_SIGR;
                  state_in    = S_SIGR;
               end
               default: begin
                  cmd.start = 1'b1;
                  cmd.src   = SRC_FINAL;
                  state_in  = S_FIN;
               end
            endcase
         end
         S_KEY: begin
            if (status.unit_done) begin
               cmd.base_from_unit = 1'b1;
               cmd.pacc_one       = 1'b1;
               cmd.exp_load_r     = 1'b1;
               state_in           = S_POW;
            end
         end
         S_SIGR: begin
            if (status.unit_done) begin
               cmd.base_from_unit = 1'b1;
               cmd.pacc_one       = 1'b1;
               cmd.exp_load_s     = 1'b1;
               state_in           = S_POW;
            end
         end
         S_FIN: begin
            if (status.unit_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = status.match && !status.p_small;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_RIGHT;
         rsp_valid_ff <= 1'b0;
         rsp_res_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_res_ff   <= rsp_res_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_res_ff;

   `ELGSV_ASSERT(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT), "result beat raised outside the output state")
   `ELGSV_ASSERT(a_load_idle, clock, reset, cmd.load |=> (state_ff == S_CHECK), "item captured without starting the check")
   `ELGSV_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> (state_ff == S_IDLE && !rsp_valid_ff), "controller not idle after reset")

endmodule

`default_nettype wire

/* hw/rtl/elgamal_signature_verify.sv */
// Sequence: from the accepting edge the hash pass, then the three powers, each after its base
// reduction pass, then the final product pass and the result beat.
// Each power runs one step per exponent bit, with a multiply when the bit is set, and the
// top step skips the square. A modulus of 0 or 1 goes straight to the result beat.
// Throughput: one item at a time; the next beat is accepted at the edge after rsp_tvalid rises.
// Reset: synchronous; clears control and loads modulus 23, generator 5, public key 17.
`default_nettype none

module elgamal_signature_verify import elgsv_pkg::*; #(
   parameter int MOD_WIDTH = 31
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request stream: one signature per beat.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [127:0]          req_tdata,   // message[62:0], sig_r[93:63], sig_s[124:94]
   // Response stream: one verdict per request beat.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // valid_res[0]
   // Register writes: modulus, generator, public key.
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [MOD_WIDTH-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       rsp_res;

   // The controller walks the sequence; the datapath owns all operand storage.
   elgsv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_res   (rsp_res),
      .cmd       (cmd),
      .status    (status)
   );

   elgsv_dp #(.MOD_WIDTH(MOD_WIDTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .message   (req_tdata[MSG_W-1:0]),
      .sig_r     (req_tdata[MSG_W+SIG_W-1:MSG_W]),
      .sig_s     (req_tdata[MSG_W+2*SIG_W-1:MSG_W+SIG_W]),
      .cmd       (cmd),
      .status    (status)
   );

   // Upper tdata bits of the response beat are padding.
   assign rsp_tdata = {7'b0, rsp_res};

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the ElGamal signature verifier.
// Depends on elgsv_pkg and the elgamal_signature_verify RTL; reads no files.
`default_nettype none

module tb_top;
   import elgsv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MW = 31;

   // One request beat: the message and the two signature halves.
   typedef struct {
      logic [MSG_W-1:0] msg;
      logic [SIG_W-1:0] sig_r;
      logic [SIG_W-1:0] sig_s;
   } sig_item_type;

   // One register setting of the group. The signing key is drawn at random
   // when p > 3; a modulus below 3 is not a usable prime, so only unsigned noise is sent.
   typedef struct {
      logic [MW-1:0]     p;
      logic [MW-1:0]     g;
      longint unsigned   x;
      int                count;
   } group_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [127:0]    req_tdata = '0;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [7:0]      rsp_tdata;
   logic            csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_MODULUS;
   logic [MW-1:0]   csr_wdata = '0;

   // Shadow copy of the group registers used by the verdict predictor.
   logic [MW-1:0]   grp_p = MW'(RST_MODULUS);
   logic [MW-1:0]   grp_g = MW'(RST_GENERATOR);
   logic [MW-1:0]   grp_y = MW'(RST_PUBLIC_KEY);

   sig_item_type    pending_sigs[$];
   logic            verdicts_due[$];
   sig_item_type    in_flight;
   int              req_gap = 0;
   int              rsp_gap = 0;
   bit              calm = 1'b0;
   int              errors = 0;
   int              beats_in = 0;
   int              beats_out = 0;
   int              accepted_ones = 0;

   always #5 clock = ~clock;

   elgamal_signature_verify #(.MOD_WIDTH(MW)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Square-and-multiply power; the modulus stays below 2^31 so every
   // product fits in 64 bits.
   function automatic longint unsigned pow_mod_p(longint unsigned base, longint unsigned e,
                                                 longint unsigned m);
      longint unsigned acc;
      longint unsigned b;
      acc = 1;
      b = base % m;
      while (e != 0) begin
         if (e[0]) acc = (acc * b) % m;
         e = e >> 1;
         b = (b * b) % m;
      end
      return acc;
   endfunction

   // Predicts the verdict bit for one beat from the current group registers.
   function automatic logic signature_holds(sig_item_type it);
      longint unsigned p;
      longint unsigned hash;
      longint unsigned lhs;
      longint unsigned rhs;
      p = grp_p;
      // A modulus of zero or one gives no group, so nothing can verify.
      if (p < 2) return 1'b0;
      hash = longint'(it.msg) % (p - 1);
      lhs = (pow_mod_p(grp_y, it.sig_r, p) * pow_mod_p(it.sig_r, it.sig_s, p)) % p;
      rhs = pow_mod_p(grp_g, hash, p);
      return lhs == rhs;
   endfunction

   function automatic longint unsigned gcd_u(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Inverse of k modulo n by the extended Euclidean algorithm.
   function automatic longint unsigned inv_mod(longint unsigned k, longint unsigned n);
      longint q, r0, r1, t0, t1, tmp;
      r0 = n; r1 = k; t0 = 0; t1 = 1;
      while (r1 != 0) begin
         q = r0 / r1;
         tmp = r0 - q * r1; r0 = r1; r1 = tmp;
         tmp = t0 - q * t1; t0 = t1; t1 = tmp;
      end
      if (t0 < 0) t0 = t0 + longint'(n);
      return longint'(t0);
   endfunction

   function automatic logic [MSG_W-1:0] rand_msg();
      return MSG_W'({$urandom(), $urandom()});
   endfunction

   // Builds an honest signature of a random message under the current group,
   // with the per-signature nonce k chosen coprime to p - 1.
   function automatic sig_item_type sign_random(longint unsigned x);
      sig_item_type it;
      longint unsigned p, n, k, hash, xr;
      p = grp_p;
      n = p - 1;
      it.msg = rand_msg();
      do begin
         k = (p > 3) ? $urandom_range(1, 32'(p - 2)) : 1;
      end while (gcd_u(k, n) != 1);
      it.sig_r = SIG_W'(pow_mod_p(grp_g, k, p));
      hash = longint'(it.msg) % n;
      xr = (x * longint'(it.sig_r)) % n;
      it.sig_s = SIG_W'((((hash + n - xr) % n) * inv_mod(k, n)) % n);
      return it;
   endfunction

   function automatic sig_item_type noise_item();
      sig_item_type it;
      it.msg = rand_msg();
      case ($urandom_range(0, 3))
         0: begin
            it.sig_r = SIG_W'($urandom());
            it.sig_s = SIG_W'($urandom());
         end
         1: begin
            it.sig_r = SIG_W'($urandom_range(0, 32'(grp_p) + 2));
            it.sig_s = SIG_W'($urandom_range(0, 32'(grp_p) + 2));
         end
         2: begin
            it.sig_r = SIG_W'($urandom_range(0, 3));
            it.sig_s = SIG_W'($urandom_range(0, 3));
         end
         default: begin
            it.sig_r = '1;
            it.sig_s = SIG_W'($urandom());
         end
      endcase
      return it;
   endfunction

   // Request driver. The beat in flight is predicted at the edge that
   // accepts it, before the next one replaces it.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            verdicts_due.push_back(signature_holds(in_flight));
            beats_in++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_sigs.size() > 0) begin
               in_flight = pending_sigs.pop_front();
               req_tdata <= {3'b0, in_flight.sig_s, in_flight.sig_r, in_flight.msg};
               req_tvalid <= 1'b1;
               if (!calm && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 16);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random back-pressure in bursts.
   always @(posedge clock) begin
      logic want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beats_out++;
            if (verdicts_due.size() == 0) begin
               $display("%0t: unexpected verdict beat, expected none, actual %h", $realtime,
                        rsp_tdata);
               errors++;
            end else begin
               want = verdicts_due.pop_front();
               if (want) accepted_ones++;
               if (rsp_tdata !== {7'b0, want}) begin
                  $display("%0t: verdict mismatch, expected %h, actual %h", $realtime,
                           {7'b0, want}, rsp_tdata);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [MW-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MODULUS:   grp_p = val;
         CSR_GENERATOR: grp_g = val;
         default:       grp_y = val;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_sigs.size() != 0 || req_tvalid || verdicts_due.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      group_type       groups[$];
      group_type       grp;
      sig_item_type    it;
      longint unsigned key;
      logic [MW-1:0]   y_val;
      int              limit;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The reset group is p = 23, g = 5, y = 17; find its private key.
      key = 1;
      while (pow_mod_p(RST_GENERATOR, key, RST_MODULUS) != RST_PUBLIC_KEY) key++;

      // Directed beats under the reset group: field extremes, a zero and a
      // full exponent, r at and past the modulus, and honest signatures.
      it.msg = '0; it.sig_r = '0; it.sig_s = '0; pending_sigs.push_back(it);
      it.msg = '1; it.sig_r = '1; it.sig_s = '1; pending_sigs.push_back(it);
      it.msg = '1; it.sig_r = '0; it.sig_s = '1; pending_sigs.push_back(it);
      it.msg = '0; it.sig_r = '1; it.sig_s = '0; pending_sigs.push_back(it);
      it.msg = 63'd22; it.sig_r = 31'd23; it.sig_s = 31'd1; pending_sigs.push_back(it);
      it.msg = 63'd44; it.sig_r = 31'd46; it.sig_s = 31'd21; pending_sigs.push_back(it);
      it.msg = 63'd1; it.sig_r = 31'd1; it.sig_s = 31'd0; pending_sigs.push_back(it);
      for (int i = 0; i < 12; i++) pending_sigs.push_back(sign_random(key));
      for (int i = 0; i < 150; i++)
         pending_sigs.push_back(($urandom_range(0, 2) != 0) ? sign_random(key) : noise_item());
      wait_drained();

      // Later groups: smallest prime, largest 31-bit prime, a generator of
      // p - 1, registers above the modulus, the degenerate moduli, then two more primes.
      grp.p = 31'd3;          grp.g = 31'd2;          grp.x = 1;  grp.count = 160;
      groups.push_back(grp);
      grp.p = 31'h7FFFFFFF;   grp.g = 31'd7;          grp.x = 0;  grp.count = 200;
      groups.push_back(grp);
      grp.p = 31'h7FFFFFFF;   grp.g = 31'h7FFFFFFE;   grp.x = 0;  grp.count = 120;
      groups.push_back(grp);
      grp.p = 31'd7919;       grp.g = 31'h7FFFFFFF;   grp.x = 0;  grp.count = 160;
      groups.push_back(grp);
      grp.p = 31'd0;          grp.g = 31'd0;          grp.x = 0;  grp.count = 40;
      groups.push_back(grp);
      grp.p = 31'd1;          grp.g = 31'd1;          grp.x = 0;  grp.count = 40;
      groups.push_back(grp);
      grp.p = 31'd2;          grp.g = 31'd1;          grp.x = 0;  grp.count = 40;
      groups.push_back(grp);
      grp.p = 31'd65521;      grp.g = 31'd17;         grp.x = 0;  grp.count = 200;
      groups.push_back(grp);
      grp.p = 31'd1000003;    grp.g = 31'd2;          grp.x = 0;  grp.count = 180;
      groups.push_back(grp);

      foreach (groups[gi]) begin
         grp = groups[gi];
         // The last group runs with both sides flat out.
         calm = (gi == groups.size() - 1);
         if (grp.p > 3) grp.x = $urandom_range(1, 32'(grp.p) - 2);
         write_reg(CSR_MODULUS, grp.p);
         write_reg(CSR_GENERATOR, grp.g);
         if (grp.p >= 3) y_val = MW'(pow_mod_p(grp.g, grp.x, grp.p));
         else y_val = '1;
         write_reg(CSR_PUBLIC_KEY, y_val);
         for (int i = 0; i < grp.count; i++) begin
            if (grp.p >= 3 && $urandom_range(0, 2) != 0) begin
               it = sign_random(grp.x);
               // Now and then break an honest signature.
               if ($urandom_range(0, 7) == 0) it.sig_s = it.sig_s + 1'b1;
            end else begin
               it = noise_item();
            end
            pending_sigs.push_back(it);
         end
         wait_drained();
      end

      limit = 0;
      while (limit < 200) begin
         @(posedge clock);
         limit++;
      end
      if (verdicts_due.size() != 0) begin
         $display("%0t: %0d verdicts never arrived", $realtime, verdicts_due.size());
         errors++;
      end
      $display("Checked %0d signatures over %0d register settings, %0d of them valid.",
               beats_out, groups.size() + 1, accepted_ones);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog: ends the run with an error if it hangs.
   initial begin
      #400_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

/* elgamal_signature_verify.f */
+incdir+hw/rtl
hw/rtl/elgsv_pkg.sv
hw/rtl/elgsv_mmu.sv
hw/rtl/elgsv_dp.sv
hw/rtl/elgsv_ctrl.sv
hw/rtl/elgamal_signature_verify.sv
tb/tb_top.sv
